FILE: src/pci_pkg.sv
// ----------------------------------------------------------------------------
// pci_pkg: shared types and constants of the clamped-integral PID controller
// Request layout, configuration bundle, register indexes and the clamp helper.
// ----------------------------------------------------------------------------
`default_nettype none

package pci_pkg;

    localparam int DATA_W      = 32;
    localparam int GAIN_W      = 32;
    localparam int LIMIT_W     = 31;
    localparam int CFG_IDX_W   = 3;
    localparam int GAIN_FRAC_W = 24;
    localparam int SUM_W       = 44;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd4;

    localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RESET = 31'd32768000;
    localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RESET   = 31'd131072000;

    // Command codes
    localparam logic CMD_RUN   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic                     clear;
        logic signed [DATA_W-1:0] error;
    } pci_req_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [LIMIT_W-1:0] integral_limit;
        logic [LIMIT_W-1:0] output_limit;
    } pci_cfg_t;

    // Clamp a wide signed value to +-lim
    function automatic logic signed [DATA_W-1:0] clamp_sym(
        input logic signed [SUM_W-1:0] x,
        input logic [LIMIT_W-1:0]      lim
    );
        logic signed [SUM_W-1:0] lim_pos;
        logic signed [SUM_W-1:0] lim_neg;
        lim_pos = $signed({{(SUM_W-LIMIT_W){1'b0}}, lim});
        lim_neg = -lim_pos;
        if (x > lim_pos)
        begin
            return lim_pos[DATA_W-1:0];
        end
        else if (x < lim_neg)
        begin
            return lim_neg[DATA_W-1:0];
        end
        return x[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/pci_front.sv
// ----------------------------------------------------------------------------
// pci_front: request intake
// Classify each request, form the saturated error and push it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_front (
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          command,
    input  wire logic signed [31:0]            setpoint,
    input  wire logic signed [31:0]            measurement,
    output logic                               q_push,
    output pci_pkg::pci_req_t                  q_data,
    input  wire logic                          q_full
);
    import pci_pkg::*;

    logic signed [DATA_W:0]   diff_wide;
    logic signed [DATA_W-1:0] error_sat;

    // Wide subtract, then saturate when the two top bits disagree
    assign diff_wide = {setpoint[DATA_W-1], setpoint} - {measurement[DATA_W-1], measurement};

    always_comb
    begin
        if (diff_wide[DATA_W] != diff_wide[DATA_W-1])
        begin
            error_sat = diff_wide[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                          : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            error_sat = diff_wide[DATA_W-1:0];
        end
    end

    assign full         = q_full;
    assign q_push       = push && !q_full;
    assign q_data.clear = (command == CMD_CLEAR);
    assign q_data.error = error_sat;

endmodule

`default_nettype wire

FILE: src/pci_queue.sv
// ----------------------------------------------------------------------------
// pci_queue: request queue between intake and execution
// Small register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_queue #(
    parameter int DEPTH = pci_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire pci_pkg::pci_req_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output pci_pkg::pci_req_t      pop_data,
    output logic                   empty
);
    import pci_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pci_req_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/pci_back.sv
// ----------------------------------------------------------------------------
// pci_back: control-step execution
// Sequence the three gain products through one 33x16 multiplier, update the
// integral, clamp the drive value and hold it in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire pci_pkg::pci_cfg_t          cfg,
    input  wire logic                       q_empty,
    input  wire pci_pkg::pci_req_t          q_data,
    output logic                            q_pop,
    output logic                            empty,
    input  wire logic                       pop,
    output logic signed [31:0]              drive_value
);
    import pci_pkg::*;

    localparam int PP_W  = DATA_W + 1 + 17;
    localparam int ACC_W = PP_W + 16;
    localparam int TERM_W = ACC_W - GAIN_FRAC_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_ACC   = 5'b00100,
        ST_TERM  = 5'b01000,
        ST_CLAMP = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        PROD_INTEG = 2'd0,
        PROD_PROP  = 2'd1,
        PROD_DERIV = 2'd2
    } prod_t;

    state_t                     state_reg, state_next;
    prod_t                      prod_reg, prod_next;
    logic                       half_reg, half_next;
    logic signed [DATA_W-1:0]   err_reg, err_next;
    logic signed [DATA_W:0]     diff_reg, diff_next;
    logic signed [DATA_W-1:0]   prev_err_reg, prev_err_next;
    logic signed [DATA_W-1:0]   integ_reg, integ_next;
    logic signed [PP_W-1:0]     pp_reg, pp_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [DATA_W-1:0]   drive_reg, drive_next;
    logic                       valid_reg, valid_next;

    logic signed [DATA_W:0]     mul_x;
    logic [GAIN_W-1:0]          mul_gain;
    logic [15:0]                gain_half;
    logic signed [TERM_W-1:0]   term;
    logic                       slot_free;

    // Operand and gain for the current product
    always_comb
    begin
        case (prod_reg)
            PROD_INTEG: mul_gain = cfg.integ_gain;
            PROD_PROP:  mul_gain = cfg.prop_gain;
            PROD_DERIV: mul_gain = cfg.deriv_gain;
            default:    mul_gain = '0;
        endcase
        mul_x = (prod_reg == PROD_DERIV) ? diff_reg : {err_reg[DATA_W-1], err_reg};
    end

    assign gain_half = half_reg ? mul_gain[31:16] : mul_gain[15:0];
    assign pp_next   = PP_W'(mul_x) * PP_W'($signed({1'b0, gain_half}));
    assign term      = acc_reg[ACC_W-1:GAIN_FRAC_W];
    assign slot_free = !valid_reg || pop;

    always_comb
    begin
        state_next    = state_reg;
        prod_next     = prod_reg;
        half_next     = half_reg;
        err_next      = err_reg;
        diff_next     = diff_reg;
        prev_err_next = prev_err_reg;
        integ_next    = integ_reg;
        acc_next      = acc_reg;
        sum_next      = sum_reg;
        drive_next    = drive_reg;
        valid_next    = valid_reg && !pop;
        q_pop         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_data.clear)
                    begin
                        integ_next = '0;
                    end
                    else
                    begin
                        err_next      = q_data.error;
                        diff_next     = {q_data.error[DATA_W-1], q_data.error}
                                      - {prev_err_reg[DATA_W-1], prev_err_reg};
                        prev_err_next = q_data.error;
                        prod_next     = PROD_INTEG;
                        half_next     = 1'b0;
                        state_next    = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (!half_reg)
                begin
                    acc_next   = {{(ACC_W-PP_W){pp_reg[PP_W-1]}}, pp_reg};
                    half_next  = 1'b1;
                    state_next = ST_MUL;
                end
                else
                begin
                    acc_next   = acc_reg + {pp_reg, 16'b0};
                    half_next  = 1'b0;
                    state_next = ST_TERM;
                end
            end
            ST_TERM:
            begin
                case (prod_reg)
                    PROD_INTEG:
                    begin
                        integ_next = clamp_sym(
                            {{(SUM_W-DATA_W){integ_reg[DATA_W-1]}}, integ_reg}
                            + {{(SUM_W-TERM_W){term[TERM_W-1]}}, term},
                            cfg.integral_limit);
                        prod_next  = PROD_PROP;
                        state_next = ST_MUL;
                    end
                    PROD_PROP:
                    begin
                        sum_next   = {{(SUM_W-DATA_W){integ_reg[DATA_W-1]}}, integ_reg}
                                   + {{(SUM_W-TERM_W){term[TERM_W-1]}}, term};
                        prod_next  = PROD_DERIV;
                        state_next = ST_MUL;
                    end
                    default:
                    begin
                        sum_next   = sum_reg + {{(SUM_W-TERM_W){term[TERM_W-1]}}, term};
                        state_next = ST_CLAMP;
                    end
                endcase
            end
            ST_CLAMP:
            begin
                // Hold until the result register can take the value
                if (slot_free)
                begin
                    drive_next = clamp_sym(sum_reg, cfg.output_limit);
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            prod_reg     <= PROD_INTEG;
            half_reg     <= 1'b0;
            prev_err_reg <= '0;
            integ_reg    <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            prod_reg     <= prod_next;
            half_reg     <= half_next;
            prev_err_reg <= prev_err_next;
            integ_reg    <= integ_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        diff_reg  <= diff_next;
        pp_reg    <= pp_next;
        acc_reg   <= acc_next;
        sum_reg   <= sum_next;
        drive_reg <= drive_next;
    end

    assign empty       = !valid_reg;
    assign drive_value = drive_reg;

endmodule

`default_nettype wire

FILE: src/pid_clamped_integral.sv
// ----------------------------------------------------------------------------
// pid_clamped_integral: positional PID controller with integral clamp
// Fixed-point PID step with queue-style request and result ports.
// ----------------------------------------------------------------------------
// A run request (command 0) carries a signed Q16.16 setpoint and measurement;
// the block forms the saturated error, adds integ_gain*error to the integral
// (clamped to +-integral_limit), and returns one drive_value equal to
// prop_gain*error + integral + deriv_gain*(error - previous error), clamped
// to +-output_limit. A clear request (command 1) zeroes the integral and
// returns nothing. Gains are unsigned Q8.24 and each product is floored by
// 24 bits. In the execution unit a run request uses the single 33x16
// multiplier twice for each of the three gain products, and a clear only
// zeroes the integral. Requests are taken every cycle while the
// QUEUE_DEPTH-entry request queue has room, also while a finished result
// still waits to be popped. Write configuration only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_clamped_integral #(
    parameter int QUEUE_DEPTH = pci_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Request side
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic                               command,
    input  wire logic signed [31:0]                 setpoint,
    input  wire logic signed [31:0]                 measurement,
    // Result side
    output logic                                    empty,
    input  wire logic                               pop,
    output logic signed [31:0]                      drive_value,
    // Configuration
    input  wire logic                               cfg_write,
    input  wire logic [pci_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pci_pkg::GAIN_W-1:0]         cfg_data
);
    import pci_pkg::*;

    pci_cfg_t cfg_reg;
    pci_cfg_t cfg_next;
    pci_req_t front_data;
    pci_req_t queue_data;
    logic     front_push;
    logic     queue_full;
    logic     queue_empty;
    logic     queue_pop;

    // Register writes; limits keep their low 31 bits, unknown indexes drop
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_PROP_GAIN:      cfg_next.prop_gain      = cfg_data;
                REG_INTEG_GAIN:     cfg_next.integ_gain     = cfg_data;
                REG_DERIV_GAIN:     cfg_next.deriv_gain     = cfg_data;
                REG_INTEGRAL_LIMIT: cfg_next.integral_limit = cfg_data[LIMIT_W-1:0];
                REG_OUTPUT_LIMIT:   cfg_next.output_limit   = cfg_data[LIMIT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain      <= '0;
            cfg_reg.integ_gain     <= '0;
            cfg_reg.deriv_gain     <= '0;
            cfg_reg.integral_limit <= INTEGRAL_LIMIT_RESET;
            cfg_reg.output_limit   <= OUTPUT_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Intake: saturate the error and classify the request
    pci_front u_front (
        .push        (push),
        .full        (full),
        .command     (command),
        .setpoint    (setpoint),
        .measurement (measurement),
        .q_push      (front_push),
        .q_data      (front_data),
        .q_full      (queue_full)
    );

    // Decouple intake from the multi-cycle execution unit
    pci_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (front_data),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_data  (queue_data),
        .empty     (queue_empty)
    );

    // Execution: gain products, integral update, output clamp, result register
    pci_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_empty     (queue_empty),
        .q_data      (queue_data),
        .q_pop       (queue_pop),
        .empty       (empty),
        .pop         (pop),
        .drive_value (drive_value)
    );

endmodule

`default_nettype wire

FILE: tb/pid_clamped_integral_tb.sv
// ----------------------------------------------------------------------------
// pid_clamped_integral_tb: self-checking bench for the clamped-integral PID
// Drives run and clear requests through the queue-style ports. A bit-exact
// controller model in the bench predicts every drive value. Each popped value
// is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module pid_clamped_integral_tb;

    import pci_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 8;
    // The execution unit may still hold a request and up to two more can wait
    // in the request queue, so this covers a trailing clear as well.
    localparam int SETTLE_CYCLES    = 80;
    localparam int DRAIN_LIMIT      = 4000;
    localparam int RANDOM_PER_PHASE = 175;
    localparam int MAX_REPORTS      = 10;
    localparam int TIMEOUT_TIME     = 5_000_000;

    // Indexes past the register list; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_OUTPUT_LIMIT + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

    localparam logic signed [DATA_W-1:0] Q16_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q16_MIN   = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q16_ONE   = 32'sh0001_0000;
    localparam logic [GAIN_W-1:0]        GAIN_ONE  = 32'h0100_0000;
    localparam logic [GAIN_W-1:0]        GAIN_FULL = '1;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------------
    logic                        clk;
    logic                        rst_n       = 1'b0;
    logic                        push        = 1'b0;
    logic                        full;
    logic                        command     = CMD_RUN;
    logic signed [DATA_W-1:0]    setpoint    = '0;
    logic signed [DATA_W-1:0]    measurement = '0;
    logic                        empty;
    logic                        pop         = 1'b0;
    logic signed [DATA_W-1:0]    drive_value;
    logic                        cfg_write   = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index   = '0;
    logic [GAIN_W-1:0]           cfg_data    = '0;

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    pid_clamped_integral i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .setpoint    (setpoint),
        .measurement (measurement),
        .empty       (empty),
        .pop         (pop),
        .drive_value (drive_value),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Controller model: registers and state as the block holds them
    // ------------------------------------------------------------------------
    logic [GAIN_W-1:0]        cfg_prop_gain      = '0;
    logic [GAIN_W-1:0]        cfg_integ_gain     = '0;
    logic [GAIN_W-1:0]        cfg_deriv_gain     = '0;
    logic [LIMIT_W-1:0]       cfg_integral_limit = INTEGRAL_LIMIT_RESET;
    logic [LIMIT_W-1:0]       cfg_output_limit   = OUTPUT_LIMIT_RESET;
    logic signed [DATA_W-1:0] pid_prev_error     = '0;
    logic signed [DATA_W-1:0] pid_integral       = '0;

    // Predicted drive values, oldest first
    logic signed [DATA_W-1:0] drive_pending[$];

    int error_count    = 0;
    int requests_sent  = 0;
    int clears_sent    = 0;
    int drives_checked = 0;
    int send_idle_pct  = 0;
    int pop_stall_pct  = 0;

    // Exact gain product, floored by the 24 fraction bits of the gain
    function automatic logic signed [79:0] scale_by_gain(
        input logic [GAIN_W-1:0]  gain,
        input logic signed [33:0] x
    );
        logic signed [79:0] g;
        logic signed [79:0] v;
        g = $signed({48'd0, gain});
        v = 80'(x);
        return (g * v) >>> GAIN_FRAC_W;
    endfunction

    function automatic logic signed [79:0] clamp_to(
        input logic signed [79:0] x,
        input logic [LIMIT_W-1:0] lim
    );
        logic signed [79:0] hi;
        hi = $signed({49'd0, lim});
        if (x > hi)
        begin
            return hi;
        end
        if (x < -hi)
        begin
            return -hi;
        end
        return x;
    endfunction

    // One control step: update integral and previous error, return the drive
    function automatic logic signed [DATA_W-1:0] advance_controller(
        input logic signed [DATA_W-1:0] sp,
        input logic signed [DATA_W-1:0] ms
    );
        logic signed [33:0]       diff;
        logic signed [33:0]       err_step;
        logic signed [DATA_W-1:0] err;
        logic signed [79:0]       integ;
        logic signed [79:0]       drive;
        diff = 34'(sp) - 34'(ms);
        if (diff > 34'sd2147483647)
        begin
            err = Q16_MAX;
        end
        else if (diff < -34'sd2147483648)
        begin
            err = Q16_MIN;
        end
        else
        begin
            err = diff[DATA_W-1:0];
        end
        integ = clamp_to(80'(pid_integral) + scale_by_gain(cfg_integ_gain, 34'(err)),
                         cfg_integral_limit);
        pid_integral = integ[DATA_W-1:0];
        // derivative difference is 33 bits wide and never saturated
        err_step = 34'(err) - 34'(pid_prev_error);
        drive = scale_by_gain(cfg_prop_gain, 34'(err)) + integ
              + scale_by_gain(cfg_deriv_gain, err_step);
        drive = clamp_to(drive, cfg_output_limit);
        pid_prev_error = err;
        return drive[DATA_W-1:0];
    endfunction

    function automatic void load_register(
        input logic [CFG_IDX_W-1:0] idx,
        input logic [GAIN_W-1:0]    data
    );
        case (idx)
            REG_PROP_GAIN:      cfg_prop_gain      = data;
            REG_INTEG_GAIN:     cfg_integ_gain     = data;
            REG_DERIV_GAIN:     cfg_deriv_gain     = data;
            // limits keep only 31 bits, which keeps the clamps symmetric
            REG_INTEGRAL_LIMIT: cfg_integral_limit = data[LIMIT_W-1:0];
            REG_OUTPUT_LIMIT:   cfg_output_limit   = data[LIMIT_W-1:0];
            default:            ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------------
    task automatic note_failure(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("ERROR at %0t: %s", $time, what);
        end
    endtask

    // Call at a rising edge; returns at the edge that accepted the request.
    task automatic send_request(
        input logic                     cmd,
        input logic signed [DATA_W-1:0] sp,
        input logic signed [DATA_W-1:0] ms
    );
        // Idle the request side at random; scramble the payload meanwhile so
        // that anything sampled without push shows up as a mismatch.
        while ($urandom_range(99) < send_idle_pct)
        begin
            push        <= 1'b0;
            command     <= 1'($urandom_range(1));
            setpoint    <= $urandom;
            measurement <= $urandom;
            @(posedge clk);
        end
        push        <= 1'b1;
        command     <= cmd;
        setpoint    <= sp;
        measurement <= ms;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        requests_sent++;
        if (cmd == CMD_CLEAR)
        begin
            // clear keeps the previous error and yields no drive value
            pid_integral = '0;
            clears_sent++;
        end
        else
        begin
            drive_pending.push_back(advance_controller(sp, ms));
        end
    endtask

    // Drop push, wait for every predicted drive value, then let a trailing
    // clear work its way out before anything else happens.
    task automatic settle();
        int waited;
        waited = 0;
        push <= 1'b0;
        while (drive_pending.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (drive_pending.size() != 0)
        begin
            note_failure($sformatf("%0d drive values never arrived", drive_pending.size()));
            drive_pending.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only call while the block is idle.
    task automatic write_register(
        input logic [CFG_IDX_W-1:0] idx,
        input logic [GAIN_W-1:0]    data
    );
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        load_register(idx, data);
        @(posedge clk);
    endtask

    task automatic write_all(
        input logic [GAIN_W-1:0] kp,
        input logic [GAIN_W-1:0] ki,
        input logic [GAIN_W-1:0] kd,
        input logic [GAIN_W-1:0] ilim,
        input logic [GAIN_W-1:0] olim
    );
        write_register(REG_PROP_GAIN, kp);
        write_register(REG_INTEG_GAIN, ki);
        write_register(REG_DERIV_GAIN, kd);
        write_register(REG_INTEGRAL_LIMIT, ilim);
        write_register(REG_OUTPUT_LIMIT, olim);
    endtask

    // Mostly moderate values so the clamps do not swallow everything, with
    // full-range words and values hugging both ends mixed in.
    function automatic logic signed [DATA_W-1:0] pick_q16();
        int unsigned kind;
        kind = $urandom_range(99);
        if (kind < 30)
        begin
            return $urandom;
        end
        if (kind < 80)
        begin
            return $urandom_range(0, 1 << 21) - (1 << 20);
        end
        if (kind < 90)
        begin
            return Q16_MAX - $urandom_range(0, 255);
        end
        return Q16_MIN + $urandom_range(0, 255);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        int unsigned kind;
        kind = $urandom_range(99);
        if (kind < 60)
        begin
            return $urandom_range(0, 1 << 25);
        end
        if (kind < 80)
        begin
            return $urandom_range(0, 1 << 28);
        end
        return $urandom;
    endfunction

    // Bit 31 is random on purpose; the block must drop it.
    function automatic logic [GAIN_W-1:0] pick_limit();
        if ($urandom_range(1) != 0)
        begin
            return $urandom;
        end
        return $urandom_range(0, 1 << 26) | ($urandom_range(1) << 31);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random pop stalls and the drive value check
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    always @(posedge clk)
    begin : drive_check
        logic signed [DATA_W-1:0] want;
        if (rst_n && pop && !empty)
        begin
            if (drive_pending.size() == 0)
            begin
                note_failure($sformatf("drive_value %0d popped with no request pending",
                                       drive_value));
            end
            else
            begin
                want = drive_pending.pop_front();
                drives_checked++;
                if (drive_value !== want)
                begin
                    note_failure($sformatf("drive_value expected %0d (0x%08h), got %0d (0x%08h)",
                                           want, want, drive_value, drive_value));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Gains are zero out of reset, so every drive must be zero even when the
    // error saturates in either direction.
    task automatic test_reset_state();
        send_request(CMD_RUN, '0, '0);
        send_request(CMD_RUN, Q16_MAX, Q16_MIN);
        send_request(CMD_RUN, Q16_MIN, Q16_MAX);
        send_request(CMD_CLEAR, '0, '0);
        settle();
    endtask

    // Full-scale gains and limits: saturated error both ways, a derivative
    // swing of almost 2^32, a clear in between and rounding of tiny errors.
    task automatic test_gain_extremes();
        write_all(GAIN_FULL, GAIN_FULL, GAIN_FULL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(CMD_RUN, Q16_MAX, Q16_MIN);
        send_request(CMD_RUN, Q16_MIN, Q16_MAX);
        send_request(CMD_RUN, Q16_MAX, Q16_MIN);
        send_request(CMD_CLEAR, Q16_MAX, Q16_MAX);
        send_request(CMD_RUN, 32'sd1, '0);
        send_request(CMD_RUN, -32'sd1, '0);
        settle();
    endtask

    // Limit writes with bit 31 set: zero limits pin everything to zero, an
    // all-ones write gives the widest clamp.
    task automatic test_limit_masking();
        write_register(REG_INTEGRAL_LIMIT, 32'h8000_0000);
        write_register(REG_OUTPUT_LIMIT, 32'h8000_0000);
        send_request(CMD_RUN, Q16_MAX, '0);
        send_request(CMD_RUN, '0, Q16_MAX);
        settle();
        write_register(REG_INTEGRAL_LIMIT, 32'h8000_0001);
        write_register(REG_OUTPUT_LIMIT, 32'hFFFF_FFFF);
        send_request(CMD_RUN, Q16_MAX, Q16_MIN);
        settle();
    endtask

    // Writes past the register list must leave every register untouched.
    task automatic test_unused_registers();
        write_register(REG_SPARE_LO, '0);
        write_register(REG_SPARE_HI, '0);
        send_request(CMD_RUN, 32'sh0001_8000, 32'sh0000_4000);
        send_request(CMD_RUN, 32'sh0000_4000, 32'sh0001_8000);
        settle();
    endtask

    // Unity proportional and derivative gains, an integral gain of 1/16 and reset limits: a plain closed-loop sequence.
    task automatic test_unity_gains();
        write_all(GAIN_ONE, GAIN_ONE >> 4, GAIN_ONE,
                  {1'b0, INTEGRAL_LIMIT_RESET}, {1'b0, OUTPUT_LIMIT_RESET});
        send_request(CMD_RUN, 2 * Q16_ONE, '0);
        send_request(CMD_RUN, Q16_ONE, 3 * Q16_ONE);
        send_request(CMD_CLEAR, '0, '0);
        send_request(CMD_RUN, '0, Q16_ONE >>> 1);
        settle();
    endtask

    // Random configuration, then a long run of requests with occasional
    // clears under the given idle and stall rates.
    task automatic test_random_phase(input int idle_pct, input int stall_pct);
        logic cmd;
        send_idle_pct = idle_pct;
        pop_stall_pct = stall_pct;
        write_all(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit());
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
        begin
            cmd = ($urandom_range(99) < 8) ? CMD_CLEAR : CMD_RUN;
            send_request(cmd, pick_q16(), pick_q16());
        end
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_gain_extremes();
        test_limit_masking();
        test_unused_registers();
        test_unity_gains();
        test_random_phase(0, 0);
        test_random_phase(72, 0);
        test_random_phase(0, 72);
        test_random_phase(22, 22);

        $display("Sent %0d requests (%0d clears) over extreme and random register settings,",
                 requests_sent, clears_sent);
        $display("checked %0d drive values under four idle/stall mixes.", drives_checked);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hard stop in case a handshake never completes
    initial
    begin
        #TIMEOUT_TIME;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
